@@ hdl/i2cmbs_pkg.sv @@
// Package with command codes, sequencer states and sequence lengths of the I2C bit sequencer.
`timescale 1ns / 1ps

package i2cmbs_pkg;

  localparam int ModeWidth  = 3;
  localparam int PhaseWidth = 5;
  localparam int ByteWidth  = 8;

  localparam logic [ModeWidth-1:0] MODE_TICK  = 3'd0;
  localparam logic [ModeWidth-1:0] MODE_START = 3'd1;
  localparam logic [ModeWidth-1:0] MODE_STOP  = 3'd2;
  localparam logic [ModeWidth-1:0] MODE_WRITE = 3'd3;
  localparam logic [ModeWidth-1:0] MODE_READ  = 3'd4;
  localparam logic [ModeWidth-1:0] MODE_ACK   = 3'd5;

  localparam logic [PhaseWidth-1:0] LEN_START = 5'd4;
  localparam logic [PhaseWidth-1:0] LEN_STOP  = 5'd3;
  localparam logic [PhaseWidth-1:0] LEN_WRITE = 5'd16;
  localparam logic [PhaseWidth-1:0] LEN_READ  = 5'd19;
  localparam logic [PhaseWidth-1:0] LEN_ACK   = 5'd3;

  localparam logic [PhaseWidth-1:0] READ_LAST_BIT = 5'd16;
  localparam logic [PhaseWidth-1:0] READ_REPLY    = 5'd17;
  localparam logic [PhaseWidth-1:0] READ_REPLY_HI = 5'd18;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_START = 6'b000010,
    ST_STOP  = 6'b000100,
    ST_WRITE = 6'b001000,
    ST_READ  = 6'b010000,
    ST_ACK   = 6'b100000
  } seq_state_t;

  function automatic logic [PhaseWidth-1:0] seq_len(input seq_state_t st);
    logic [PhaseWidth-1:0] len;
    case (st)
      ST_START: len = LEN_START;
      ST_STOP:  len = LEN_STOP;
      ST_WRITE: len = LEN_WRITE;
      ST_READ:  len = LEN_READ;
      ST_ACK:   len = LEN_ACK;
      default:  len = '0;
    endcase
    return len;
  endfunction

endpackage

@@ hdl/i2c_master_bit_sequencer_core.sv @@
// Top level of the I2C master bit sequencer: input register, phase logic and result register.
`timescale 1ns / 1ps

//  channel | direction | handshake          | payload
//  in      | input     | in_valid, in_stall | mode, data_byte, ack_to_send, sda_sample
//  out     | output    | out_valid, out_stall | scl_level, sda_level, busy_res, done_res,
//          |           |                    | read_data, ack_received
//
// One tick is taken per clock cycle while the output is not stalled; each tick yields exactly one result beat.
// An accepted beat is held in the input register, then the phase logic loads the result register
// and the sequencer state from it once the output can take a beat.
// A stall on the output holds the result register and then the input register in turn.
// Reset is synchronous and returns the lines to released and the sequencer to idle.

module i2c_master_bit_sequencer_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] mode,
  input  logic [7:0] data_byte,
  input  logic       ack_to_send,
  input  logic       sda_sample,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       scl_level,
  output logic       sda_level,
  output logic       busy_res,
  output logic       done_res,
  output logic [7:0] read_data,
  output logic       ack_received
);

  logic                                   s1_valid;
  logic [i2cmbs_pkg::ModeWidth-1:0]       s1_mode;
  logic [i2cmbs_pkg::ByteWidth-1:0]       s1_data;
  logic                                   s1_ack;
  logic                                   s1_sda;

  i2cmbs_pkg::seq_state_t                 state;
  logic [i2cmbs_pkg::PhaseWidth-1:0]      phase;
  logic [i2cmbs_pkg::ByteWidth-1:0]       shift_byte;
  logic                                   reply_bit;
  logic                                   clock_out;
  logic                                   data_out;
  logic                                   received_ack;
  logic [i2cmbs_pkg::ByteWidth-1:0]       held_read;

  i2cmbs_pkg::seq_state_t                 state_next;
  i2cmbs_pkg::seq_state_t                 cmd;
  logic [i2cmbs_pkg::PhaseWidth-1:0]      phase_next;
  logic [i2cmbs_pkg::PhaseWidth-1:0]      p;
  logic [i2cmbs_pkg::ByteWidth-1:0]       shift_byte_next;
  logic                                   reply_bit_next;
  logic                                   clock_out_next;
  logic                                   data_out_next;
  logic                                   received_ack_next;
  logic [i2cmbs_pkg::ByteWidth-1:0]       held_read_next;
  logic                                   done_next;

  logic out_ready;
  logic advance;
  logic in_take;

  assign out_ready = !out_valid || !out_stall;
  assign advance   = s1_valid && out_ready;
  assign in_stall  = s1_valid && !advance;
  assign in_take   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_mode <= mode;
      s1_data <= data_byte;
      s1_ack  <= ack_to_send;
      s1_sda  <= sda_sample;
    end
  end

  always_comb begin
    cmd               = state;
    shift_byte_next   = shift_byte;
    reply_bit_next    = reply_bit;
    clock_out_next    = clock_out;
    data_out_next     = data_out;
    received_ack_next = received_ack;
    held_read_next    = held_read;
    done_next         = 1'b0;
    state_next        = state;
    phase_next        = phase;

    if (state == i2cmbs_pkg::ST_IDLE) begin
      case (s1_mode)
        i2cmbs_pkg::MODE_START: cmd = i2cmbs_pkg::ST_START;
        i2cmbs_pkg::MODE_STOP:  cmd = i2cmbs_pkg::ST_STOP;
        i2cmbs_pkg::MODE_WRITE: begin
          cmd             = i2cmbs_pkg::ST_WRITE;
          shift_byte_next = s1_data;
        end
        i2cmbs_pkg::MODE_READ: begin
          cmd             = i2cmbs_pkg::ST_READ;
          shift_byte_next = '0;
          reply_bit_next  = s1_ack;
        end
        i2cmbs_pkg::MODE_ACK:   cmd = i2cmbs_pkg::ST_ACK;
        default:                cmd = i2cmbs_pkg::ST_IDLE;
      endcase
    end

    // The phase is zero whenever the sequencer is idle, so this is also the first tick.
    p = phase + 5'd1;

    case (cmd)
      i2cmbs_pkg::ST_START: begin
        if (p == 5'd1) begin
          data_out_next = 1'b1;
        end else if (p == 5'd2) begin
          clock_out_next = 1'b1;
        end else if (p == 5'd3) begin
          data_out_next = 1'b0;
        end else begin
          clock_out_next = 1'b0;
        end
      end
      i2cmbs_pkg::ST_STOP: begin
        if (p == 5'd1) begin
          clock_out_next = 1'b0;
          data_out_next  = 1'b0;
        end else if (p == 5'd2) begin
          clock_out_next = 1'b1;
        end else begin
          data_out_next = 1'b1;
        end
      end
      i2cmbs_pkg::ST_WRITE: begin
        if (p[0]) begin
          if (p != 5'd1) begin
            clock_out_next = 1'b0;
          end
          data_out_next = shift_byte_next[7];
        end else begin
          shift_byte_next = {shift_byte_next[6:0], 1'b0};
          clock_out_next  = (p != i2cmbs_pkg::LEN_WRITE);
        end
      end
      i2cmbs_pkg::ST_READ: begin
        if (p <= i2cmbs_pkg::READ_LAST_BIT) begin
          if (p[0]) begin
            if (p == 5'd1) begin
              data_out_next = 1'b1;
            end else begin
              clock_out_next = 1'b0;
            end
          end else begin
            clock_out_next  = 1'b1;
            shift_byte_next = {shift_byte_next[6:0], s1_sda};
          end
        end else if (p == i2cmbs_pkg::READ_REPLY) begin
          clock_out_next = 1'b0;
          data_out_next  = reply_bit_next;
        end else if (p == i2cmbs_pkg::READ_REPLY_HI) begin
          clock_out_next = 1'b1;
        end else begin
          clock_out_next = 1'b0;
          data_out_next  = 1'b1;
          held_read_next = shift_byte_next;
        end
      end
      i2cmbs_pkg::ST_ACK: begin
        if (p == 5'd1) begin
          data_out_next = 1'b1;
        end else if (p == 5'd2) begin
          clock_out_next    = 1'b1;
          received_ack_next = s1_sda;
        end else begin
          clock_out_next = 1'b0;
        end
      end
      default: begin
      end
    endcase

    if (cmd != i2cmbs_pkg::ST_IDLE) begin
      if (p >= i2cmbs_pkg::seq_len(cmd)) begin
        done_next  = 1'b1;
        state_next = i2cmbs_pkg::ST_IDLE;
        phase_next = '0;
      end else begin
        state_next = cmd;
        phase_next = p;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= i2cmbs_pkg::ST_IDLE;
      phase        <= '0;
      shift_byte   <= '0;
      reply_bit    <= 1'b1;
      clock_out    <= 1'b1;
      data_out     <= 1'b1;
      received_ack <= 1'b1;
      held_read    <= '0;
    end else if (advance) begin
      state        <= state_next;
      phase        <= phase_next;
      shift_byte   <= shift_byte_next;
      reply_bit    <= reply_bit_next;
      clock_out    <= clock_out_next;
      data_out     <= data_out_next;
      received_ack <= received_ack_next;
      held_read    <= held_read_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      scl_level    <= clock_out_next;
      sda_level    <= data_out_next;
      busy_res     <= (state_next != i2cmbs_pkg::ST_IDLE);
      done_res     <= done_next;
      read_data    <= held_read_next;
      ack_received <= received_ack_next;
    end
  end

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && done_res) |-> !busy_res)
    else $error("Completion beat still reports busy.");

  a_idle_phase_zero: assert property (@(posedge clk) disable iff (rst)
    (state == i2cmbs_pkg::ST_IDLE) |-> (phase == '0))
    else $error("Phase count is not cleared while idle.");

  a_phase_bound: assert property (@(posedge clk) disable iff (rst)
    phase < i2cmbs_pkg::LEN_READ)
    else $error("Phase count ran past the longest sequence.");

  a_start_bound: assert property (@(posedge clk) disable iff (rst)
    (state == i2cmbs_pkg::ST_START) |-> (phase < i2cmbs_pkg::LEN_START))
    else $error("Start sequence ran past its length.");

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (rst)
    !advance |=> ($stable(state) && $stable(phase) && $stable(held_read)))
    else $error("Sequencer state moved without a tick.");

endmodule

@@ bench/i2c_master_bit_sequencer_core_tb.sv @@
// Self-checking testbench for the I2C master bit sequencer core, with a built-in line-level predictor.
`timescale 1ns / 1ps

module i2c_master_bit_sequencer_core_tb;

  localparam logic [i2cmbs_pkg::ModeWidth-1:0] MODE_SPARE_6 = 3'd6;
  localparam logic [i2cmbs_pkg::ModeWidth-1:0] MODE_SPARE_7 = 3'd7;
  localparam int QuietLimit = 4000;
  localparam int PhaseItems = 290;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    logic [7:0] rdata;
    logic       ack;
  } line_result_t;

  class tick_scoreboard;
    logic [i2cmbs_pkg::PhaseWidth-1:0] phase;
    logic [i2cmbs_pkg::ModeWidth-1:0]  cmd;
    logic [i2cmbs_pkg::ByteWidth-1:0]  shreg;
    logic [i2cmbs_pkg::ByteWidth-1:0]  held_byte;
    logic                              reply;
    logic                              scl;
    logic                              sda;
    logic                              ack_rx;
    line_result_t                      line_q[$];
    int                                errors;
    int                                ticks;
    int                                started[8];
    int                                completed;
    int                                ignored;

    function new();
      phase = '0;
      cmd = i2cmbs_pkg::MODE_TICK;
      shreg = '0;
      held_byte = '0;
      reply = 1'b1;
      scl = 1'b1;
      sda = 1'b1;
      ack_rx = 1'b1;
      errors = 0;
      ticks = 0;
      completed = 0;
      ignored = 0;
      foreach (started[i]) started[i] = 0;
    endfunction

    static function int seq_ticks(logic [i2cmbs_pkg::ModeWidth-1:0] c);
      case (c)
        i2cmbs_pkg::MODE_START: return i2cmbs_pkg::LEN_START;
        i2cmbs_pkg::MODE_STOP:  return i2cmbs_pkg::LEN_STOP;
        i2cmbs_pkg::MODE_WRITE: return i2cmbs_pkg::LEN_WRITE;
        i2cmbs_pkg::MODE_READ:  return i2cmbs_pkg::LEN_READ;
        i2cmbs_pkg::MODE_ACK:   return i2cmbs_pkg::LEN_ACK;
        default:                return 0;
      endcase
    endfunction

    function void note_tick(logic [2:0] m, logic [7:0] d, logic a, logic s);
      line_result_t r;
      logic fin;
      fin = 1'b0;
      ticks++;
      if (m >= i2cmbs_pkg::MODE_START && m <= i2cmbs_pkg::MODE_ACK) begin
        if (cmd == i2cmbs_pkg::MODE_TICK) begin
          cmd = m;
          phase = '0;
          started[m]++;
          if (m == i2cmbs_pkg::MODE_WRITE) shreg = d;
          if (m == i2cmbs_pkg::MODE_READ) begin
            shreg = '0;
            reply = a;
          end
        end else begin
          ignored++;
        end
      end
      if (cmd != i2cmbs_pkg::MODE_TICK) begin
        phase = phase + 5'd1;
        case (cmd)
          i2cmbs_pkg::MODE_START: begin
            if (phase == 1) sda = 1'b1;
            else if (phase == 2) scl = 1'b1;
            else if (phase == 3) sda = 1'b0;
            else scl = 1'b0;
          end
          i2cmbs_pkg::MODE_STOP: begin
            if (phase == 1) begin
              scl = 1'b0;
              sda = 1'b0;
            end else if (phase == 2) begin
              scl = 1'b1;
            end else begin
              sda = 1'b1;
            end
          end
          i2cmbs_pkg::MODE_WRITE: begin
            if (phase[0]) begin
              if (phase != 1) scl = 1'b0;
              sda = shreg[7];
            end else begin
              shreg = shreg << 1;
              scl = (phase != i2cmbs_pkg::LEN_WRITE);
            end
          end
          i2cmbs_pkg::MODE_READ: begin
            if (phase <= i2cmbs_pkg::READ_LAST_BIT) begin
              if (phase[0]) begin
                if (phase == 1) sda = 1'b1;
                else scl = 1'b0;
              end else begin
                scl = 1'b1;
                shreg = {shreg[6:0], s};
              end
            end else if (phase == i2cmbs_pkg::READ_REPLY) begin
              scl = 1'b0;
              sda = reply;
            end else if (phase == i2cmbs_pkg::READ_REPLY_HI) begin
              scl = 1'b1;
            end else begin
              scl = 1'b0;
              sda = 1'b1;
              held_byte = shreg;
            end
          end
          default: begin
            if (phase == 1) sda = 1'b1;
            else if (phase == 2) begin
              scl = 1'b1;
              ack_rx = s;
            end else begin
              scl = 1'b0;
            end
          end
        endcase
        if (phase >= seq_ticks(cmd)) begin
          fin = 1'b1;
          completed++;
          cmd = i2cmbs_pkg::MODE_TICK;
          phase = '0;
        end
      end
      r.scl = scl;
      r.sda = sda;
      r.busy = (cmd != i2cmbs_pkg::MODE_TICK);
      r.done = fin;
      r.rdata = held_byte;
      r.ack = ack_rx;
      line_q.push_back(r);
    endfunction

    function void match_field(string name, int want, int got);
      if (want != got) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(line_result_t got);
      line_result_t want;
      if (line_q.size() == 0) begin
        $error("result beat arrived with no tick outstanding");
        errors++;
        return;
      end
      want = line_q.pop_front();
      match_field("scl_level", want.scl, got.scl);
      match_field("sda_level", want.sda, got.sda);
      match_field("busy_res", want.busy, got.busy);
      match_field("done_res", want.done, got.done);
      match_field("read_data", want.rdata, got.rdata);
      match_field("ack_received", want.ack, got.ack);
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [2:0] mode = i2cmbs_pkg::MODE_TICK;
  logic [7:0] data_byte = 8'h00;
  logic       ack_to_send = 1'b0;
  logic       sda_sample = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       scl_level;
  logic       sda_level;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_data;
  logic       ack_received;

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int sent_items = 0;
  int quiet_cycles = 0;
  tick_scoreboard sb = new();

  i2c_master_bit_sequencer_core uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .mode(mode),
    .data_byte(data_byte),
    .ack_to_send(ack_to_send),
    .sda_sample(sda_sample),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .scl_level(scl_level),
    .sda_level(sda_level),
    .busy_res(busy_res),
    .done_res(done_res),
    .read_data(read_data),
    .ack_received(ack_received)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= !rst && ($urandom_range(99) < rx_stall_pct);
  end

  // Everything changes at the rising edge, so the falling edge sees what the next edge takes.
  always @(negedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        sb.check_result({scl_level, sda_level, busy_res, done_res, read_data, ack_received});
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("[i2c_master_bit_sequencer_core] ERROR");
        $finish;
      end
    end
  end

  task automatic send_tick(input logic [2:0] m, input logic [7:0] d, input logic a,
                           input logic s);
    logic held;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    data_byte <= d;
    ack_to_send <= a;
    sda_sample <= s;
    do begin
      @(negedge clk);
      held = in_stall;
      if (!held) sb.note_tick(m, d, a, s);
      @(posedge clk);
    end while (held);
    sent_items++;
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Issues a command beat followed by the filler ticks that carry it to completion.
  // A filler beat may carry another command, which the busy sequencer must ignore.
  task automatic run_command(input logic [2:0] cmd, input logic [7:0] data_v, input logic ack_v,
                             input int inject_at);
    int n;
    logic [2:0] fill;
    n = tick_scoreboard::seq_ticks(cmd);
    send_tick(cmd, data_v, ack_v, 1'($urandom_range(1)));
    for (int k = 1; k < n; k++) begin
      if (k == inject_at) fill = i2cmbs_pkg::MODE_WRITE;
      else if ($urandom_range(9) == 0) fill = 3'($urandom_range(7));
      else fill = i2cmbs_pkg::MODE_TICK;
      send_tick(fill, pick_byte(), 1'($urandom_range(1)), 1'($urandom_range(1)));
    end
  endtask

  task automatic random_phase(input int target);
    int stop_at;
    stop_at = sent_items + target;
    while (sent_items < stop_at) begin
      if ($urandom_range(4) != 0) begin
        run_command(3'($urandom_range(i2cmbs_pkg::MODE_ACK, i2cmbs_pkg::MODE_START)),
                    pick_byte(), 1'($urandom_range(1)), -1);
      end else begin
        repeat ($urandom_range(3, 1)) begin
          send_tick(3'($urandom_range(7)), pick_byte(), 1'($urandom_range(1)),
                    1'($urandom_range(1)));
        end
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    tx_idle_pct = 6;
    rx_stall_pct = 67;
    send_tick(i2cmbs_pkg::MODE_TICK, 8'hFF, 1'b1, 1'b1);
    send_tick(MODE_SPARE_6, 8'h00, 1'b0, 1'b0);
    run_command(i2cmbs_pkg::MODE_START, 8'h00, 1'b0, -1);
    run_command(i2cmbs_pkg::MODE_READ, 8'hFF, 1'b0, 5);
    run_command(i2cmbs_pkg::MODE_ACK, 8'h00, 1'b1, 2);
    run_command(i2cmbs_pkg::MODE_STOP, 8'h00, 1'b1, -1);
    send_tick(MODE_SPARE_7, 8'hFF, 1'b1, 1'b1);
    random_phase(PhaseItems);

    tx_idle_pct = 67;
    rx_stall_pct = 6;
    random_phase(PhaseItems);

    tx_idle_pct = 0;
    rx_stall_pct = 0;
    random_phase(PhaseItems);

    in_valid <= 1'b0;
    while (sb.line_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Ran %0d ticks: %0d start, %0d stop, %0d write, %0d read, %0d acknowledge sample.",
             sb.ticks, sb.started[i2cmbs_pkg::MODE_START], sb.started[i2cmbs_pkg::MODE_STOP],
             sb.started[i2cmbs_pkg::MODE_WRITE], sb.started[i2cmbs_pkg::MODE_READ],
             sb.started[i2cmbs_pkg::MODE_ACK]);
    $display("%0d commands ran to completion and %0d arrived while busy and were dropped.",
             sb.completed, sb.ignored);
    if (sb.errors == 0 && sb.line_q.size() == 0) begin
      $display("[i2c_master_bit_sequencer_core] OK");
    end else begin
      $display("[i2c_master_bit_sequencer_core] ERROR");
    end
    $finish;
  end

endmodule
